// ===== rtl/mslcg_pkg.sv =====
// Shared constants for the minimal-standard Lehmer generator.
package mslcg_pkg;

	// Lehmer multiplier and the Mersenne prime modulus 2^31 - 1
	localparam logic [31:0] LCG_MULT = 32'd16807;
	localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;

	// Largest run length of one request
	localparam logic [6:0] MAX_COUNT = 7'd64;

	// Configuration register indexes
	localparam logic [0:0] REG_LOWER = 1'b0;
	localparam logic [0:0] REG_UPPER = 1'b1;

endpackage

// ===== rtl/minimal_standard_lcg_uniform_int_unit.sv =====
// Minimal-standard Lehmer generator with a uniform integer output in a configured interval.
// Each request optionally loads a new seed, then advances the seed count times
// (seed := seed * 16807 mod (2^31 - 1), count saturated to 64) and emits one result per
// step: the raw 31-bit seed and lower + ((seed * (span + 1)) >> 31), with the bounds taken
// in ascending order. A zero seed gives a single result with error set. One 32x32
// multiplier is shared by the seed update and the scaling, so each result passes through
// multiply, modular reduce, multiply and scale; the request port stalls until the run is
// done. Bounds are to be written through the configuration port (index 0 lower, 1 upper)
// only while idle; the block itself does not enforce this.
module minimal_standard_lcg_uniform_int_unit (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [6:0]         count,
	input  logic               load_seed,
	input  logic [30:0]        new_seed,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [30:0]        raw_seed,
	output logic               last,
	output logic               error,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_RED,
		ST_MUL2,
		ST_SCALE,
		ST_ERR
	} state_t;

	state_t      state_q;
	logic [30:0] seed_q;
	logic [31:0] lower_q;
	logic [31:0] upper_q;
	logic [31:0] lo_q;
	logic [31:0] span_q;
	logic [6:0]  remain_q;
	logic [63:0] prod_q;

	logic        out_free;
	logic        out_load;
	logic        in_fire;
	logic [30:0] start_seed;
	logic [6:0]  sat_count;
	logic        swap;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [31:0] red_sum;
	logic [30:0] red_seed;
	logic [63:0] scale_sum;
	logic [31:0] scaled;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign out_load  = ((state_q == ST_SCALE) || (state_q == ST_ERR)) && out_free;

	// Pick the starting seed; loading the modulus itself stores zero
	always_comb begin
		if (load_seed) begin
			start_seed = (new_seed == mslcg_pkg::LCG_MOD) ? 31'd0 : new_seed;
		end else begin
			start_seed = seed_q;
		end
	end

	assign sat_count = (count > mslcg_pkg::MAX_COUNT) ? mslcg_pkg::MAX_COUNT : count;
	assign swap      = $signed(upper_q) < $signed(lower_q);

	// Shared multiplier: seed times 16807, or seed times span
	assign mul_b = (state_q == ST_MUL1) ? mslcg_pkg::LCG_MULT : span_q;
	assign mul_p = {32'd0, 1'b0, seed_q} * {32'd0, mul_b};

	// Fold the high bits back in mod 2^31 - 1, one conditional subtract
	assign red_sum  = {17'd0, prod_q[45:31]} + {1'b0, prod_q[30:0]};
	assign red_seed = (red_sum >= {1'b0, mslcg_pkg::LCG_MOD}) ?
		31'(red_sum - {1'b0, mslcg_pkg::LCG_MOD}) : red_sum[30:0];

	// seed * (span + 1) = seed * span + seed, then take bits above 31
	assign scale_sum = prod_q + {33'd0, seed_q};
	assign scaled    = lo_q + scale_sum[62:31];

	// Sequencer, seed, bounds and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seed_q    <= 31'd1;
			lower_q   <= 32'd0;
			upper_q   <= 32'd255;
			lo_q      <= 32'd0;
			span_q    <= 32'd0;
			remain_q  <= 7'd0;
			prod_q    <= 64'd0;
			out_valid <= 1'b0;
			value     <= 32'sd0;
			raw_seed  <= 31'd0;
			last      <= 1'b0;
			error     <= 1'b0;
		end else begin
			// Write configuration
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mslcg_pkg::REG_LOWER: lower_q <= cfg_data;
					mslcg_pkg::REG_UPPER: upper_q <= cfg_data;
					default: ;
				endcase
			end

			// Raise valid on a new result, drop it once taken
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						seed_q   <= start_seed;
						remain_q <= sat_count;
						lo_q     <= swap ? upper_q : lower_q;
						span_q   <= swap ? (lower_q - upper_q) : (upper_q - lower_q);
						if (start_seed == 31'd0) begin
							state_q <= ST_ERR;
						end else if (sat_count != 7'd0) begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: begin
					prod_q  <= mul_p;
					state_q <= ST_RED;
				end
				ST_RED: begin
					seed_q  <= red_seed;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					prod_q  <= mul_p;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					// Hold until the result register is free
					if (out_load) begin
						value     <= scaled;
						raw_seed  <= seed_q;
						last      <= (remain_q == 7'd1);
						error     <= 1'b0;
						remain_q  <= remain_q - 7'd1;
						state_q   <= (remain_q == 7'd1) ? ST_IDLE : ST_MUL1;
					end
				end
				ST_ERR: begin
					if (out_load) begin
						value     <= 32'sd0;
						raw_seed  <= 31'd0;
						last      <= 1'b1;
						error     <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An error result always closes its request
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> last)
		else $error("error result without last");

	// A generated result never carries a zero seed
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !error) |-> (raw_seed != 31'd0))
		else $error("zero seed in generated result");

	// The seed never reaches the modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		seed_q != mslcg_pkg::LCG_MOD)
		else $error("seed equals modulus");

	// A multiply step only starts from a nonzero seed
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1) |-> (seed_q != 31'd0))
		else $error("generation from zero seed");

endmodule

// ===== test/minimal_standard_lcg_uniform_int_unit_tb.sv =====
// Self-checking testbench for the minimal-standard Lehmer generator with uniform integer output.
module minimal_standard_lcg_uniform_int_unit_tb;

	// Quiet cycles tolerated before the run is declared hung
	localparam int QUIET_LIMIT = 5000;

	typedef struct {
		logic signed [31:0] value;
		logic [30:0]        raw_seed;
		logic               last;
		logic               error;
	} draw_t;

	// Tracks seed and bounds, predicts each draw and checks the results in order
	class lehmer_scoreboard;
		logic [30:0]        seed;
		logic signed [31:0] lower;
		logic signed [31:0] upper;
		draw_t              pending[$];
		int unsigned        errors;

		function new();
			seed = 31'd1;
			lower = 32'sd0;
			upper = 32'sd255;
			errors = 0;
		endfunction

		function void set_bound(logic [0:0] index, logic [31:0] data);
			if (index == mslcg_pkg::REG_LOWER)
				lower = data;
			else
				upper = data;
		endfunction

		// Queue the draws caused by one accepted request
		function void take_request(logic [6:0] n, logic load, logic [30:0] fresh);
			longint lo;
			longint hi;
			longint tmp;
			longint span;
			longint off;
			longint v;
			int     steps;
			draw_t  d;
			if (load)
				seed = (fresh == mslcg_pkg::LCG_MOD) ? 31'd0 : fresh;
			if (seed == 31'd0) begin
				d.value = 32'sd0;
				d.raw_seed = 31'd0;
				d.last = 1'b1;
				d.error = 1'b1;
				pending.push_back(d);
				return;
			end
			lo = lower;
			hi = upper;
			if (hi < lo) begin
				tmp = lo;
				lo = hi;
				hi = tmp;
			end
			span = hi - lo;
			steps = (n > mslcg_pkg::MAX_COUNT) ? int'(mslcg_pkg::MAX_COUNT) : int'(n);
			for (int i = 0; i < steps; i++) begin
				seed = 31'((longint'(seed) * longint'(mslcg_pkg::LCG_MULT))
					% longint'(mslcg_pkg::LCG_MOD));
				off = (longint'(seed) * (span + 1)) >> 31;
				if (off > span)
					off = span;
				v = lo + off;
				if (v > hi)
					v = hi;
				d.value = 32'(v);
				d.raw_seed = seed;
				d.last = (i == steps - 1);
				d.error = 1'b0;
				pending.push_back(d);
			end
		endfunction

		function void report(string what, longint want, longint got);
			errors++;
			if (errors <= 40)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		endfunction

		// Compare one accepted result against the oldest prediction
		function void check_draw(logic signed [31:0] value, logic [30:0] raw_seed,
				logic last, logic error);
			draw_t d;
			if (pending.size() == 0) begin
				report("unexpected result, raw_seed", -1, raw_seed);
				return;
			end
			d = pending.pop_front();
			if (value !== d.value)
				report("value", d.value, value);
			if (raw_seed !== d.raw_seed)
				report("raw_seed", d.raw_seed, raw_seed);
			if (last !== d.last)
				report("last", d.last, last);
			if (error !== d.error)
				report("error", d.error, error);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [6:0]         count = '0;
	logic               load_seed = 1'b0;
	logic [30:0]        new_seed = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] value;
	logic [30:0]        raw_seed;
	logic               last;
	logic               error;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [0:0]         cfg_index = mslcg_pkg::REG_LOWER;
	logic [31:0]        cfg_data = '0;

	int unsigned in_gap_pct = 29;
	int unsigned out_stall_pct = 60;
	int unsigned quiet_cycles = 0;

	lehmer_scoreboard sb = new();

	minimal_standard_lcg_uniform_int_unit dut (.*);

	always #5 clk = ~clk;

	// Stall the result channel at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_draw(value, raw_seed, last, error);
	end

	// Count cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("minimal_standard_lcg_uniform_int_unit_tb: done, errors");
		$finish;
	end

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(input logic [6:0] n, input logic load, input logic [30:0] fresh);
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		count <= n;
		load_seed <= load;
		new_seed <= fresh;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_request(n, load, fresh);
	endtask

	// Drop the request, wait for every predicted result, then let the block go idle
	task automatic settle(input int pause);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic write_bound(input logic [0:0] index, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_bound(index, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_bound();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(300));
			3: return 32'($urandom_range(600)) - 32'd300;
			default: return $urandom;
		endcase
	endfunction

	// Mostly short runs, some long and saturated ones, now and then a load of an edge seed
	task automatic random_request();
		logic [6:0]  n;
		logic        load;
		logic [30:0] fresh;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			n = 7'd0;
		else if (pick < 75)
			n = 7'($urandom_range(1, 16));
		else if (pick < 90)
			n = 7'($urandom_range(17, 64));
		else
			n = 7'($urandom_range(65, 127));
		load = ($urandom_range(99) < 35);
		if ($urandom_range(99) < 8) begin
			case ($urandom_range(3))
				0: fresh = 31'd0;
				1: fresh = 31'd1;
				2: fresh = mslcg_pkg::LCG_MOD - 31'd1;
				default: fresh = mslcg_pkg::LCG_MOD;
			endcase
		end else begin
			fresh = 31'($urandom);
		end
		send_request(n, load, fresh);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset bounds: seed from reset, long and saturated runs, zero count with a load
		send_request(7'd1, 1'b0, 31'd0);
		send_request(7'd64, 1'b0, 31'd0);
		send_request(7'd127, 1'b1, mslcg_pkg::LCG_MOD - 31'd1);
		send_request(7'd65, 1'b1, 31'd1);
		send_request(7'd0, 1'b1, 31'd12345);
		send_request(7'd3, 1'b0, 31'd0);
		// Zero seed stays stuck until reloaded; the modulus loads as zero
		send_request(7'd5, 1'b1, 31'd0);
		send_request(7'd9, 1'b0, 31'd0);
		send_request(7'd0, 1'b0, 31'd0);
		send_request(7'd2, 1'b1, mslcg_pkg::LCG_MOD);
		send_request(7'd4, 1'b1, 31'h2AAA_AAAA);

		// Full-range interval
		settle(20);
		write_bound(mslcg_pkg::REG_LOWER, 32'h8000_0000);
		write_bound(mslcg_pkg::REG_UPPER, 32'h7FFF_FFFF);
		send_request(7'd16, 1'b1, mslcg_pkg::LCG_MOD - 31'd1);
		send_request(7'd8, 1'b1, 31'h5555_5555);

		// Reversed bounds
		settle(20);
		write_bound(mslcg_pkg::REG_LOWER, 32'd1000);
		write_bound(mslcg_pkg::REG_UPPER, -32'sd1000);
		send_request(7'd12, 1'b0, 31'd0);
		send_request(7'd1, 1'b1, 31'd1);

		// Reversed full range
		settle(20);
		write_bound(mslcg_pkg::REG_LOWER, 32'h7FFF_FFFF);
		write_bound(mslcg_pkg::REG_UPPER, 32'h8000_0000);
		send_request(7'd20, 1'b0, 31'd0);

		// Single-point intervals at -5 and at the largest value
		settle(20);
		write_bound(mslcg_pkg::REG_LOWER, -32'sd5);
		write_bound(mslcg_pkg::REG_UPPER, -32'sd5);
		send_request(7'd6, 1'b0, 31'd0);
		settle(20);
		write_bound(mslcg_pkg::REG_UPPER, 32'h7FFF_FFFF);
		write_bound(mslcg_pkg::REG_LOWER, 32'h7FFF_FFFF);
		send_request(7'd3, 1'b0, 31'd0);

		// Random traffic under three idle profiles, new bounds every few dozen requests
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					in_gap_pct = 29;
					out_stall_pct = 60;
				end
				1: begin
					in_gap_pct = 60;
					out_stall_pct = 29;
				end
				default: begin
					in_gap_pct = 0;
					out_stall_pct = 0;
				end
			endcase
			repeat (4) begin
				settle(20);
				write_bound(mslcg_pkg::REG_LOWER, random_bound());
				write_bound(mslcg_pkg::REG_UPPER, random_bound());
				repeat (38) random_request();
			end
		end

		settle(300);
		if (sb.errors == 0)
			$display("minimal_standard_lcg_uniform_int_unit_tb: done, clean");
		else
			$display("minimal_standard_lcg_uniform_int_unit_tb: done, errors");
		$finish;
	end

endmodule
